### sv/drt_pkg.sv
package drt_pkg;

  localparam int MaxRegions = 64;
  localparam int IdxW = $clog2(MaxRegions);
  localparam int CntW = $clog2(MaxRegions + 1);

  localparam logic [1:0] FuncAdd   = 2'd0;
  localparam logic [1:0] FuncFull  = 2'd1;
  localparam logic [1:0] FuncFlush = 2'd2;

  localparam logic [1:0] CfgWidth  = 2'd0;
  localparam logic [1:0] CfgHeight = 2'd1;
  localparam logic [1:0] CfgMaxAge = 2'd2;
  localparam logic [1:0] CfgThresh = 2'd3;

  // stored box: x,y 13 bits, w,h 14 bits
  typedef struct packed {
    logic [12:0] x;
    logic [12:0] y;
    logic [13:0] w;
    logic [13:0] h;
  } box_t;

  // controller to datapath
  typedef struct packed {
    logic       add;       // accept add item into store
    logic       full_req;  // full-damage item
    logic       flush_start;
    logic       rd_req;    // read entry rd_idx
    logic [IdxW-1:0] rd_idx;
    logic       load_cur;  // load current box from read data
    logic       test_j;    // compare read data against current box
    logic       mul_step;  // product stage of merge test, merge decision
    logic       emit;      // current box finished, write to result queue
    logic       emit_empty;
    logic       flush_done;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic [CntW-1:0] count;
    logic [MaxRegions-1:0] consumed;
    logic            out_busy;
  } stat_t;

endpackage

### sv/drt_datapath.sv
module drt_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  drt_pkg::ctrl_t      ctrl_i,
  output drt_pkg::stat_t      stat_o,
  input  logic [14:0]         rect_x_i,
  input  logic [14:0]         rect_y_i,
  input  logic [14:0]         rect_w_i,
  input  logic [14:0]         rect_h_i,
  input  logic                cfg_valid_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                region_valid_o,
  output logic [12:0]         out_x_o,
  output logic [12:0]         out_y_o,
  output logic [13:0]         out_w_o,
  output logic [13:0]         out_h_o,
  output logic                full_redraw_o,
  output logic [6:0]          region_total_o,
  output logic [31:0]         damaged_area_o,
  output logic [15:0]         frame_age_o,
  output logic                last_o
);
  import drt_pkg::*;

  logic [13:0] sw_q, sh_q;
  logic [15:0] max_age_q;
  logic [8:0]  thr_q;
  logic [CntW-1:0] count_q;
  logic [MaxRegions-1:0] cons_q;
  logic        flag_q;
  logic [15:0] age_q;

  box_t mem [MaxRegions];
  box_t rd_q;
  box_t cur_q;

  // result queue, holds up to MaxRegions boxes before they go out
  box_t oq [MaxRegions];
  box_t ob_q;
  logic [CntW-1:0] oq_wr_q, oq_rd_q, n_q;
  logic        draining_q;
  logic        verdict_q;
  logic [15:0] fage_q;
  logic [32:0] area_q;
  logic        empty_q;

  // add clipping
  logic signed [15:0] ax, ay, aw, ah, sws, shs;
  logic signed [16:0] rx, by;
  logic add_ok;
  always_comb begin
    sws = (sw_q > 14'd8192) ? 16'sd8192 : $signed({2'b0, sw_q});
    shs = (sh_q > 14'd8192) ? 16'sd8192 : $signed({2'b0, sh_q});
    ax = $signed({rect_x_i[14], rect_x_i});
    ay = $signed({rect_y_i[14], rect_y_i});
    aw = $signed({rect_w_i[14], rect_w_i});
    ah = $signed({rect_h_i[14], rect_h_i});
    add_ok = (aw > 0) && (ah > 0);
    if (ax < 0) begin
      aw = aw + ax;
      ax = '0;
    end
    if (ay < 0) begin
      ah = ah + ay;
      ay = '0;
    end
    rx = 17'(ax) + 17'(aw);
    by = 17'(ay) + 17'(ah);
    if (rx > 17'(sws)) aw = sws - ax;
    if (by > 17'(shs)) ah = shs - ay;
    add_ok = add_ok && (aw > 0) && (ah > 0);
  end

  // merge test: stage 1 overlap dims and bbox, stage 2 products
  logic [14:0] cr, cb, jr, jb, lft, top, rgt, bot;
  logic [13:0] ow_d, oh_d;
  box_t bb_d, bb_q;
  always_comb begin
    cr = 15'(cur_q.x) + 15'(cur_q.w);
    cb = 15'(cur_q.y) + 15'(cur_q.h);
    jr = 15'(rd_q.x) + 15'(rd_q.w);
    jb = 15'(rd_q.y) + 15'(rd_q.h);
    lft = (cur_q.x > rd_q.x) ? 15'(cur_q.x) : 15'(rd_q.x);
    top = (cur_q.y > rd_q.y) ? 15'(cur_q.y) : 15'(rd_q.y);
    rgt = (cr < jr) ? cr : jr;
    bot = (cb < jb) ? cb : jb;
    ow_d = (rgt > lft) ? 14'(rgt - lft) : '0;
    oh_d = (bot > top) ? 14'(bot - top) : '0;
    bb_d.x = (cur_q.x < rd_q.x) ? cur_q.x : rd_q.x;
    bb_d.y = (cur_q.y < rd_q.y) ? cur_q.y : rd_q.y;
    bb_d.w = 14'(((cr > jr) ? cr : jr) - 15'(bb_d.x));
    bb_d.h = 14'(((cb > jb) ? cb : jb) - 15'(bb_d.y));
  end

  logic [27:0] ov_q, aj_q;
  logic [IdxW-1:0] j_q;
  logic [36:0] lhs, rhs;
  logic        merge;
  assign lhs = {ov_q, 8'd0} + 37'd0;
  assign rhs = 37'(thr_q) * 37'(aj_q);
  assign merge = lhs >= rhs;

  logic [27:0] cur_area;
  assign cur_area = cur_q.w * cur_q.h;

  // queue read address: first entry at the end of the walk, then the next one per taken result
  logic [IdxW-1:0] oq_rd_idx;
  assign oq_rd_idx = ctrl_i.flush_done ? '0 : IdxW'(oq_rd_q + 1'b1);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.add && add_ok && count_q < CntW'(MaxRegions))
      mem[count_q[IdxW-1:0]] <= '{x: ax[12:0], y: ay[12:0], w: aw[13:0], h: ah[13:0]};
    if (ctrl_i.rd_req) rd_q <= mem[ctrl_i.rd_idx];
    if (ctrl_i.emit) oq[oq_wr_q[IdxW-1:0]] <= cur_q;
    if (ctrl_i.flush_done || (draining_q && !out_stall_i)) ob_q <= oq[oq_rd_idx];
  end

  // stage registers (payload)
  always_ff @(posedge clk_i) begin
    bb_q <= bb_d;
    if (ctrl_i.test_j) begin
      ov_q <= ow_d * oh_d;
      aj_q <= rd_q.w * rd_q.h;
      j_q  <= ctrl_i.rd_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= 14'd1920; sh_q <= 14'd1080; max_age_q <= 16'd60; thr_q <= 9'd128;
      count_q <= '0; cons_q <= '0; flag_q <= 1'b1; age_q <= '0;
      oq_wr_q <= '0; oq_rd_q <= '0; n_q <= '0; draining_q <= 1'b0;
      verdict_q <= 1'b0; fage_q <= '0; area_q <= '0; empty_q <= 1'b0;
      cur_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgWidth:  sw_q <= cfg_data_i[13:0];
          CfgHeight: sh_q <= cfg_data_i[13:0];
          CfgMaxAge: max_age_q <= cfg_data_i[15:0];
          CfgThresh: thr_q <= cfg_data_i[8:0];
          default: ;
        endcase
      end
      if (ctrl_i.add && add_ok) begin
        if (count_q < CntW'(MaxRegions)) count_q <= count_q + 1'b1;
        else flag_q <= 1'b1;
      end
      if (ctrl_i.full_req) begin
        flag_q <= 1'b1;
        age_q <= '0;
      end
      if (ctrl_i.flush_start) begin
        verdict_q <= flag_q || (age_q >= ((max_age_q == 0) ? 16'd1 : max_age_q));
        fage_q <= age_q;
        cons_q <= '0;
        area_q <= '0;
        oq_wr_q <= '0;
      end
      if (ctrl_i.load_cur) begin
        cur_q <= rd_q;
        cons_q[ctrl_i.rd_idx] <= 1'b1;
      end
      if (ctrl_i.mul_step && aj_q != 0 && merge) begin
        cur_q <= bb_q;
        cons_q[j_q] <= 1'b1;
      end
      if (ctrl_i.emit) begin
        oq_wr_q <= oq_wr_q + 1'b1;
        area_q <= area_q + 33'(cur_area);
      end
      if (ctrl_i.flush_done) begin
        count_q <= '0;
        cons_q <= '0;
        age_q <= (age_q != 16'hFFFF) ? age_q + 1'b1 : age_q;
        flag_q <= ((age_q != 16'hFFFF) ? age_q + 1'b1 : age_q)
                  >= ((max_age_q == 0) ? 16'd1 : max_age_q);
        n_q <= ctrl_i.emit_empty ? CntW'(1) : oq_wr_q;
        empty_q <= ctrl_i.emit_empty;
        oq_rd_q <= '0;
        draining_q <= 1'b1;
      end
      if (draining_q && !out_stall_i) begin
        if (oq_rd_q + 1'b1 == n_q) draining_q <= 1'b0;
        oq_rd_q <= oq_rd_q + 1'b1;
      end
    end
  end

  // area_q sums at most 64 boxes of 2^26, so 33 bits cover it
  logic is_last;
  assign is_last = (oq_rd_q + 1'b1 == n_q);

  assign out_valid_o    = draining_q;
  assign region_valid_o = !empty_q;
  assign out_x_o        = empty_q ? '0 : ob_q.x;
  assign out_y_o        = empty_q ? '0 : ob_q.y;
  assign out_w_o        = empty_q ? '0 : ob_q.w;
  assign out_h_o        = empty_q ? '0 : ob_q.h;
  assign full_redraw_o  = verdict_q;
  assign region_total_o = empty_q ? 7'd0 : 7'(n_q);
  assign damaged_area_o = !is_last ? '0 : (area_q[32] ? 32'hFFFFFFFF : area_q[31:0]);
  assign frame_age_o    = fage_q;
  assign last_o         = is_last;

  assign stat_o.count    = count_q;
  assign stat_o.consumed = cons_q;
  assign stat_o.out_busy = draining_q;

endmodule

### sv/drt_ctrl.sv
module drt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [1:0]     func_i,
  input  drt_pkg::stat_t stat_i,
  output drt_pkg::ctrl_t ctrl_o
);
  import drt_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRdI  = 3'd1;
  localparam logic [2:0] StLdI  = 3'd2;
  localparam logic [2:0] StRdJ  = 3'd3;
  localparam logic [2:0] StTest = 3'd4;
  localparam logic [2:0] StMul  = 3'd5;
  localparam logic [2:0] StEmit = 3'd6;
  localparam logic [2:0] StDone = 3'd7;

  logic [2:0] state_q, state_d;
  logic [CntW-1:0] i_q, i_d, j_q, j_d;
  logic [CntW-1:0] emitted_q, emitted_d;
  logic acc;

  assign in_stall_o = (state_q != StIdle) || stat_i.out_busy;
  assign acc = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q; i_d = i_q; j_d = j_q; emitted_d = emitted_q;
    ctrl_o = '0;
    ctrl_o.rd_idx = i_q[IdxW-1:0];
    unique case (state_q)
      StIdle: begin
        if (acc) begin
          ctrl_o.add      = (func_i == FuncAdd);
          ctrl_o.full_req = (func_i == FuncFull);
          if (func_i == FuncFlush) begin
            ctrl_o.flush_start = 1'b1;
            i_d = '0; emitted_d = '0;
            state_d = StRdI;
          end
        end
      end
      StRdI: begin
        if (i_q >= stat_i.count) state_d = StDone;
        else if (stat_i.consumed[i_q[IdxW-1:0]]) i_d = i_q + 1'b1;
        else begin
          ctrl_o.rd_req = 1'b1;
          state_d = StLdI;
        end
      end
      StLdI: begin
        ctrl_o.load_cur = 1'b1;
        j_d = i_q + 1'b1;
        state_d = StRdJ;
      end
      StRdJ: begin
        ctrl_o.rd_idx = j_q[IdxW-1:0];
        if (j_q >= stat_i.count) state_d = StEmit;
        else if (stat_i.consumed[j_q[IdxW-1:0]]) j_d = j_q + 1'b1;
        else begin
          ctrl_o.rd_req = 1'b1;
          state_d = StTest;
        end
      end
      StTest: begin
        ctrl_o.rd_idx = j_q[IdxW-1:0];
        ctrl_o.test_j = 1'b1;
        state_d = StMul;
      end
      StMul: begin
        ctrl_o.mul_step = 1'b1;
        j_d = j_q + 1'b1;
        state_d = StRdJ;
      end
      StEmit: begin
        ctrl_o.emit = 1'b1;
        emitted_d = emitted_q + 1'b1;
        i_d = i_q + 1'b1;
        state_d = StRdI;
      end
      StDone: begin
        ctrl_o.flush_done = 1'b1;
        ctrl_o.emit_empty = (emitted_q == '0);
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; i_q <= '0; j_q <= '0; emitted_q <= '0;
    end else begin
      state_q <= state_d; i_q <= i_d; j_q <= j_d; emitted_q <= emitted_d;
    end
  end

endmodule

### sv/damage_rectangle_tracker.sv
// damage rectangle tracker: add items (clip and store) and full-damage items
// are handled in the idle state without leaving it. a flush walks the
// 64-entry store with one memory read port: per live entry the steps read,
// load, closing scan step and emit, plus for each later live entry tested
// against it a registered read, an overlap stage and a product stage, and a
// skip step for each entry already merged away; the first result appears in
// the cycle after the walk ends, then results drain one per cycle unless the
// receiver stalls; no item is accepted until the last result is taken.
module damage_rectangle_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [14:0] rect_x_i,
  input  logic [14:0] rect_y_i,
  input  logic [14:0] rect_w_i,
  input  logic [14:0] rect_h_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        region_valid_o,
  output logic [12:0] out_x_o,
  output logic [12:0] out_y_o,
  output logic [13:0] out_w_o,
  output logic [13:0] out_h_o,
  output logic        full_redraw_o,
  output logic [6:0]  region_total_o,
  output logic [31:0] damaged_area_o,
  output logic [15:0] frame_age_o,
  output logic        last_o
);
  import drt_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // config is always taken
  assign cfg_ready_o = 1'b1;

  drt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .func_i,
    .stat_i(stat), .ctrl_o(ctrl)
  );

  drt_datapath u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .rect_x_i, .rect_y_i, .rect_w_i, .rect_h_i,
    .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .out_valid_o, .out_stall_i, .region_valid_o, .out_x_o, .out_y_o,
    .out_w_o, .out_h_o, .full_redraw_o, .region_total_o, .damaged_area_o,
    .frame_age_o, .last_o
  );

endmodule

### sv/drt_checker.sv
module drt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       region_valid_o,
  input logic       last_o,
  input logic [6:0] region_total_o,
  input logic [31:0] damaged_area_o
);
  a_stall_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken during drain");
  a_area_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> damaged_area_o == 32'd0) else $error("area off last");
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !region_valid_o |-> last_o && region_total_o == 7'd0)
    else $error("empty flush shape");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(last_o))
    else $error("result dropped");
endmodule

bind damage_rectangle_tracker drt_checker u_chk (.*);

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import drt_pkg::*;

  // one item on the damage channel
  typedef struct packed {
    logic [1:0]  func;
    logic [14:0] x;
    logic [14:0] y;
    logic [14:0] w;
    logic [14:0] h;
  } damage_item_t;

  // one result of a flush, in port order
  typedef struct packed {
    logic        rv;
    logic [12:0] x;
    logic [12:0] y;
    logic [13:0] w;
    logic [13:0] h;
    logic        redraw;
    logic [6:0]  total;
    logic [31:0] area;
    logic [15:0] age;
    logic        lst;
  } region_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  func_i;
  logic [14:0] rect_x_i, rect_y_i, rect_w_i, rect_h_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        region_valid_o;
  logic [12:0] out_x_o, out_y_o;
  logic [13:0] out_w_o, out_h_o;
  logic        full_redraw_o;
  logic [6:0]  region_total_o;
  logic [31:0] damaged_area_o;
  logic [15:0] frame_age_o;
  logic        last_o;

  damage_rectangle_tracker u_dut (.*);

  // clock, 10 ns period
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // stimulus and expectation stores
  damage_item_t pending_items[$];
  region_res_t  expected_regions[$];

  int send_idle_pct;
  int recv_idle_pct;
  int recv_hold_left;
  int mismatches;
  bit failed;
  logic in_fire;

  // shadow of the block: configuration
  int scr_w_reg, scr_h_reg, max_age_reg, thresh_reg;
  // shadow of the block: store and frame state
  int box_x[MaxRegions], box_y[MaxRegions], box_w[MaxRegions], box_h[MaxRegions];
  int box_cnt;
  bit redraw_flag;
  int frame_age_cnt;

  // per-frame hot spot, so that adds of one frame tend to overlap
  int hot_x, hot_y;

  function automatic int clamp_dim(int v);
    return (v > 8192) ? 8192 : v;
  endfunction

  // clip an add to the screen and store it; overflow of the store forces a redraw
  function automatic void store_damage(int x, int y, int w, int h);
    int sw, sh;
    sw = clamp_dim(scr_w_reg);
    sh = clamp_dim(scr_h_reg);
    if (w <= 0 || h <= 0) return;
    if (x < 0) begin
      w += x;
      x = 0;
    end
    if (y < 0) begin
      h += y;
      y = 0;
    end
    if (x + w > sw) w = sw - x;
    if (y + h > sh) h = sh - y;
    if (w <= 0 || h <= 0) return;
    if (box_cnt >= MaxRegions) begin
      redraw_flag = 1'b1;
      return;
    end
    box_x[box_cnt] = x;
    box_y[box_cnt] = y;
    box_w[box_cnt] = w;
    box_h[box_cnt] = h;
    box_cnt++;
  endfunction

  // merge the store greedily and queue the results of one flush
  function automatic void flush_frame();
    int ma, n, cx, cy, cw, ch, l, t, r, b, nr, nb, k;
    bit verdict;
    bit used[MaxRegions];
    int mx[MaxRegions], my[MaxRegions], mw[MaxRegions], mh[MaxRegions];
    longint area, aj, ov;
    region_res_t res;
    ma = (max_age_reg == 0) ? 1 : max_age_reg;
    verdict = redraw_flag || (frame_age_cnt >= ma);
    n = 0;
    area = 0;
    foreach (used[i]) used[i] = 1'b0;
    for (int i = 0; i < box_cnt; i++) begin
      if (used[i]) continue;
      cx = box_x[i]; cy = box_y[i]; cw = box_w[i]; ch = box_h[i];
      used[i] = 1'b1;
      for (int j = i + 1; j < box_cnt; j++) begin
        if (used[j]) continue;
        aj = longint'(box_w[j]) * box_h[j];
        if (aj == 0) continue;
        l = (cx > box_x[j]) ? cx : box_x[j];
        t = (cy > box_y[j]) ? cy : box_y[j];
        r = (cx + cw < box_x[j] + box_w[j]) ? cx + cw : box_x[j] + box_w[j];
        b = (cy + ch < box_y[j] + box_h[j]) ? cy + ch : box_y[j] + box_h[j];
        ov = (r <= l || b <= t) ? 0 : longint'(r - l) * (b - t);
        if (ov * 256 >= longint'(thresh_reg) * aj) begin
          nr = (cx + cw > box_x[j] + box_w[j]) ? cx + cw : box_x[j] + box_w[j];
          nb = (cy + ch > box_y[j] + box_h[j]) ? cy + ch : box_y[j] + box_h[j];
          cx = (cx < box_x[j]) ? cx : box_x[j];
          cy = (cy < box_y[j]) ? cy : box_y[j];
          cw = nr - cx;
          ch = nb - cy;
          used[j] = 1'b1;
        end
      end
      mx[n] = cx; my[n] = cy; mw[n] = cw; mh[n] = ch;
      n++;
      area += longint'(cw) * ch;
    end
    if (area > 64'hFFFF_FFFF) area = 64'hFFFF_FFFF;
    // an empty flush still reports one result without a region
    for (k = 0; k < ((n != 0) ? n : 1); k++) begin
      res.rv     = (n != 0);
      res.x      = (n != 0) ? mx[k][12:0] : '0;
      res.y      = (n != 0) ? my[k][12:0] : '0;
      res.w      = (n != 0) ? mw[k][13:0] : '0;
      res.h      = (n != 0) ? mh[k][13:0] : '0;
      res.redraw = verdict;
      res.total  = n[6:0];
      res.lst    = (k + 1 == ((n != 0) ? n : 1));
      res.area   = res.lst ? area[31:0] : '0;
      res.age    = frame_age_cnt[15:0];
      expected_regions.push_back(res);
    end
    box_cnt = 0;
    redraw_flag = 1'b0;
    if (frame_age_cnt < 65535) frame_age_cnt++;
    if (frame_age_cnt >= ma) redraw_flag = 1'b1;
  endfunction

  function automatic void track_damage(damage_item_t it);
    case (it.func)
      FuncAdd:   store_damage($signed(it.x), $signed(it.y), $signed(it.w), $signed(it.h));
      FuncFull: begin
        redraw_flag = 1'b1;
        frame_age_cnt = 0;
      end
      FuncFlush: flush_frame();
      default: ;  // unknown code, ignored by the block
    endcase
  endfunction

  function automatic damage_item_t mk_item(logic [1:0] f, int x, int y, int w, int h);
    damage_item_t it;
    it.func = f;
    it.x = x[14:0];
    it.y = y[14:0];
    it.w = w[14:0];
    it.h = h[14:0];
    return it;
  endfunction

  // an add that mostly lands on screen, half of them near the frame's hot spot
  function automatic damage_item_t rand_add();
    int lim_w, lim_h, sel;
    lim_w = (clamp_dim(scr_w_reg) > 0) ? clamp_dim(scr_w_reg) : 1;
    lim_h = (clamp_dim(scr_h_reg) > 0) ? clamp_dim(scr_h_reg) : 1;
    sel = $urandom_range(99);
    if (sel < 50)
      return mk_item(FuncAdd, hot_x + $urandom_range(0, 24) - 8, hot_y + $urandom_range(0, 24) - 8,
                     $urandom_range(1, 40), $urandom_range(1, 40));
    else if (sel < 80)
      return mk_item(FuncAdd, $urandom_range(0, lim_w - 1), $urandom_range(0, lim_h - 1),
                     $urandom_range(1, 200), $urandom_range(1, 200));
    else if (sel < 90)
      // straddles an edge of the screen
      return mk_item(FuncAdd, $urandom_range(0, 1) ? -$urandom_range(1, 300) : lim_w - 20,
                     $urandom_range(0, 1) ? -$urandom_range(1, 300) : lim_h - 20,
                     $urandom_range(1, 600), $urandom_range(1, 600));
    else
      return mk_item(FuncAdd, $urandom, $urandom, $urandom, $urandom);
  endfunction

  // queue frames of random adds, closed by a flush, with some noise between
  task automatic queue_frames(int n_items);
    int made, len;
    made = 0;
    while (made < n_items) begin
      hot_x = $urandom_range(0, (clamp_dim(scr_w_reg) > 1) ? clamp_dim(scr_w_reg) - 1 : 0);
      hot_y = $urandom_range(0, (clamp_dim(scr_h_reg) > 1) ? clamp_dim(scr_h_reg) - 1 : 0);
      len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        pending_items.push_back(rand_add());
        if ($urandom_range(29) == 0)
          pending_items.push_back(mk_item(FuncFull, $urandom, $urandom, $urandom, $urandom));
        if ($urandom_range(39) == 0)
          pending_items.push_back(mk_item(2'd3, $urandom, $urandom, $urandom, $urandom));
      end
      pending_items.push_back(mk_item(FuncFlush, $urandom, $urandom, $urandom, $urandom));
      made += len + 1;
    end
  endtask

  // let everything drain, then wait out an add still in flight
  task automatic settle();
    wait (pending_items.size() == 0 && !in_valid_i && expected_regions.size() == 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgWidth:  scr_w_reg   = val[13:0];
      CfgHeight: scr_h_reg   = val[13:0];
      CfgMaxAge: max_age_reg = val[15:0];
      CfgThresh: thresh_reg  = val[8:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // item driver: a new item only once the previous one was taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_fire) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          damage_item_t it;
          it = pending_items.pop_front();
          func_i     <= it.func;
          rect_x_i   <= it.x;
          rect_y_i   <= it.y;
          rect_w_i   <= it.w;
          rect_h_i   <= it.h;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with a long hold-off counted down here
  always @(negedge clk_i) begin
    if (recv_hold_left > 0) recv_hold_left <= recv_hold_left - 1;
    out_stall_i <= (recv_hold_left > 0) || ($urandom_range(99) < recv_idle_pct);
  end

  // monitor: predict on accepted items, check accepted results
  always @(posedge clk_i) begin
    region_res_t got, want;
    in_fire <= in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o)
      track_damage({func_i, rect_x_i, rect_y_i, rect_w_i, rect_h_i});
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {region_valid_o, out_x_o, out_y_o, out_w_o, out_h_o, full_redraw_o,
             region_total_o, damaged_area_o, frame_age_o, last_o};
      if (expected_regions.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_regions.pop_front();
        if (got != want) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10) $display("result mismatch\n  exp %p\n  got %p", want, got);
        end
      end
    end
  end

  // main sequence
  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_fire = 1'b0;
    func_i = FuncAdd;
    rect_x_i = '0; rect_y_i = '0; rect_w_i = '0; rect_h_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgWidth;
    cfg_data_i = '0;
    out_stall_i = 1'b0;
    recv_hold_left = 0;
    mismatches = 0;
    failed = 1'b0;
    scr_w_reg = 1920; scr_h_reg = 1080; max_age_reg = 60; thresh_reg = 128;
    box_cnt = 0;
    redraw_flag = 1'b1;
    frame_age_cnt = 0;
    send_idle_pct = 27;
    recv_idle_pct = 74;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: clipping extremes, empty and negative sizes, every code
    pending_items.push_back(mk_item(FuncFlush, 0, 0, 0, 0));  // nothing stored yet
    pending_items.push_back(mk_item(FuncAdd, -16384, -16384, 16383, 16383));
    pending_items.push_back(mk_item(FuncAdd, 16383, 16383, 16383, 16383));
    pending_items.push_back(mk_item(FuncAdd, 100, 100, 0, 50));
    pending_items.push_back(mk_item(FuncAdd, 100, 100, 50, -16384));
    pending_items.push_back(mk_item(FuncAdd, -20, -20, 20, 20));     // clips to empty
    pending_items.push_back(mk_item(FuncAdd, 1900, 1070, 100, 100)); // bottom-right corner
    pending_items.push_back(mk_item(FuncAdd, 10, 10, 20, 20));
    pending_items.push_back(mk_item(FuncAdd, 12, 12, 20, 20));       // overlaps the previous one
    pending_items.push_back(mk_item(FuncAdd, 500, 500, 10, 10));     // disjoint
    pending_items.push_back(mk_item(2'd3, -1, -1, -1, -1));          // unknown code
    pending_items.push_back(mk_item(FuncFlush, -1, -1, -1, -1));
    pending_items.push_back(mk_item(FuncFlush, 0, 0, 0, 0));         // empty frame
    pending_items.push_back(mk_item(FuncAdd, 0, 0, 1920, 1080));     // single region
    pending_items.push_back(mk_item(FuncFlush, 0, 0, 0, 0));
    pending_items.push_back(mk_item(FuncFull, 0, 0, 0, 0));
    pending_items.push_back(mk_item(FuncAdd, 5, 5, 5, 5));
    pending_items.push_back(mk_item(FuncFlush, 0, 0, 0, 0));
    settle();

    // zero-width screen drops every add
    write_reg(CfgWidth, 32'd0);
    pending_items.push_back(mk_item(FuncAdd, 0, 0, 10, 10));
    pending_items.push_back(mk_item(FuncFlush, 0, 0, 0, 0));
    settle();

    // oversize screen, age limit zero, merge-anything threshold
    write_reg(CfgWidth, 32'hFFFF_FFFF);
    write_reg(CfgHeight, 32'd8192);
    write_reg(CfgMaxAge, 32'd0);
    write_reg(CfgThresh, 32'd0);
    @(posedge clk_i);
    recv_hold_left = 500;  // results back up while the sender keeps offering
    queue_frames(30);
    settle();

    // sender pause mid-run: drained above, then a tiny screen and strict merging
    send_idle_pct = 74;
    recv_idle_pct = 27;
    write_reg(CfgWidth, 32'd1);
    write_reg(CfgHeight, 32'd1);
    write_reg(CfgMaxAge, 32'd65535);
    write_reg(CfgThresh, 32'd256);
    queue_frames(12);
    settle();
    write_reg(CfgWidth, 32'd640);
    write_reg(CfgHeight, 32'd480);
    write_reg(CfgThresh, 32'd128);
    write_reg(CfgMaxAge, 32'd4);
    queue_frames(45);
    settle();

    // full store: no merging, full-screen boxes, one overflow, saturating area
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CfgWidth, 32'd8192);
    write_reg(CfgHeight, 32'd8192);
    write_reg(CfgThresh, 32'd300);
    for (int i = 0; i < MaxRegions + 1; i++)
      pending_items.push_back(mk_item(FuncAdd, 0, 0, 8192, 8192));
    pending_items.push_back(mk_item(FuncFlush, 0, 0, 0, 0));
    settle();

    // neither side idles
    write_reg(CfgWidth, 32'd1920);
    write_reg(CfgHeight, 32'd1080);
    write_reg(CfgThresh, 32'd511);
    write_reg(CfgMaxAge, 32'd1);
    queue_frames(25);
    settle();
    write_reg(CfgThresh, 32'd64);
    write_reg(CfgMaxAge, 32'd60);
    queue_frames(40);
    settle();

    if (!failed)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
